// ===== rtl/rssq_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rssq_pkg
// shared constants, register codes and types of the range scan store
// ----------------------------------------------------------------------------
package rssq_pkg;

   localparam int NUM_BINS    = 360;
   localparam int WINDOW_HALF = 5;
   localparam int STAMP_BITS  = 16;

   localparam int BIN_BITS    = $clog2(NUM_BINS);
   localparam int WINDOW_LEN  = 2 * WINDOW_HALF;
   localparam int CNT_BITS    = $clog2(WINDOW_LEN + 1);
   localparam int DIST_BITS   = 16;
   localparam int WORD_BITS   = DIST_BITS + STAMP_BITS;

   localparam int ADDR_BITS   = 4;
   localparam int DATA_BITS   = 32;

   // register indexes, taken from paddr[3:2]
   localparam logic [1:0] REG_MIN_DISTANCE = 2'd0;
   localparam logic [1:0] REG_MAX_DISTANCE = 2'd1;
   localparam logic [1:0] REG_MAX_AGE      = 2'd2;
   localparam logic [1:0] REG_SIMILARITY   = 2'd3;

   localparam logic [15:0] RST_MIN_DISTANCE = 16'd100;
   localparam logic [15:0] RST_MAX_DISTANCE = 16'd3000;
   localparam logic [15:0] RST_MAX_AGE      = 16'd800;
   localparam logic [15:0] RST_SIMILARITY   = 16'd50;

   localparam logic KIND_POINT = 1'b0;
   localparam logic KIND_QUERY = 1'b1;

   typedef struct packed {
      logic [15:0] min_distance;
      logic [15:0] max_distance;
      logic [15:0] max_age;
      logic [15:0] similarity;
   } cfg_type;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_POINT,
      ST_QUERY,
      ST_RESP
   } state_type;

endpackage

// ===== rtl/rssq_csr.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rssq_csr
// apb register file holding the distance limits, age limit and similarity
// ----------------------------------------------------------------------------
module rssq_csr
   import rssq_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 psel,
   input  logic                 penable,
   input  logic                 pwrite,
   input  logic [ADDR_BITS-1:0] paddr,
   input  logic [DATA_BITS-1:0] pwdata,
   output logic [DATA_BITS-1:0] prdata,
   output logic                 pready,
   output cfg_type              cfg
);

   cfg_type cfg_ff, cfg_in;
   logic    wr_en;
   logic [1:0] idx;

   assign pready = 1'b1;
   assign idx    = paddr[3:2];
   assign wr_en  = psel && penable && pwrite;
   assign cfg    = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         unique case (idx)
            REG_MIN_DISTANCE: cfg_in.min_distance = pwdata[15:0];
            REG_MAX_DISTANCE: cfg_in.max_distance = pwdata[15:0];
            REG_MAX_AGE:      cfg_in.max_age      = pwdata[15:0];
            REG_SIMILARITY:   cfg_in.similarity   = pwdata[15:0];
            default:          cfg_in = cfg_ff;
         endcase
      end
   end

   always_comb begin
      unique case (idx)
         REG_MIN_DISTANCE: prdata = {16'd0, cfg_ff.min_distance};
         REG_MAX_DISTANCE: prdata = {16'd0, cfg_ff.max_distance};
         REG_MAX_AGE:      prdata = {16'd0, cfg_ff.max_age};
         REG_SIMILARITY:   prdata = {16'd0, cfg_ff.similarity};
         default:          prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.min_distance <= RST_MIN_DISTANCE;
         cfg_ff.max_distance <= RST_MAX_DISTANCE;
         cfg_ff.max_age      <= RST_MAX_AGE;
         cfg_ff.similarity   <= RST_SIMILARITY;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

// ===== rtl/range_scan_store_and_query_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// range_scan_store_and_query_top
// per-degree range table with time stamps, point store and direction query
// ----------------------------------------------------------------------------
// The table of 360 bins lives in one single-port-read synchronous memory of
// distance and stamp words. After reset a clearing pass writes one bin per
// cycle, during which req_ready stays low; register writes are taken at any
// time. A point request is accepted in ST_IDLE and its word is written to
// memory in ST_POINT. A query request reads its ten bins one per cycle
// through the memory's registered read port and checks each word as it
// returns, ending early when an agreeing pair shows up. A finished response
// sits in an output register, so point requests keep flowing while it waits.
module range_scan_store_and_query_top
   import rssq_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  logic                 req_kind,
   input  logic [14:0]          req_angle_q6,
   input  logic [15:0]          req_distance_mm,
   input  logic [8:0]           req_query_angle,
   input  logic [15:0]          req_now_ms,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output logic [15:0]          rsp_result_mm,
   output logic                 rsp_found,
   input  logic                 psel,
   input  logic                 penable,
   input  logic                 pwrite,
   input  logic [ADDR_BITS-1:0] paddr,
   input  logic [DATA_BITS-1:0] pwdata,
   output logic [DATA_BITS-1:0] prdata,
   output logic                 pready
);

   cfg_type cfg;

   rssq_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   // bin table: {distance, stamp}
   logic [WORD_BITS-1:0] bin_mem_ff [NUM_BINS];
   logic [WORD_BITS-1:0] rdata_ff;
   logic                 mem_we;
   logic [BIN_BITS-1:0]  mem_waddr;
   logic [WORD_BITS-1:0] mem_wdata;
   logic                 mem_re;
   logic [BIN_BITS-1:0]  mem_raddr;

   always_ff @(posedge clock) begin
      if (mem_we) begin
         bin_mem_ff[mem_waddr] <= mem_wdata;
      end
      if (mem_re) begin
         rdata_ff <= bin_mem_ff[mem_raddr];
      end
   end

   state_type             state_ff, state_in;
   logic [BIN_BITS-1:0]   clr_ff, clr_in;
   logic [BIN_BITS-1:0]   addr_ff, addr_in;
   logic [CNT_BITS-1:0]   cnt_ff, cnt_in;
   logic                  rd_valid_ff, rd_valid_in;
   logic                  rd_last_ff, rd_last_in;
   logic                  have_prev_ff, have_prev_in;
   logic [DIST_BITS-1:0]  prev_ff, prev_in;
   logic [DIST_BITS-1:0]  res_mm_ff, res_mm_in;
   logic                  res_found_ff, res_found_in;
   logic [STAMP_BITS-1:0] now_ff, now_in;
   logic [DIST_BITS-1:0]  dist_ff, dist_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [DIST_BITS-1:0]  rsp_mm_ff, rsp_mm_in;
   logic                  rsp_found_ff, rsp_found_in;

   // point angle rounded half-up, then one wrap past the last bin
   logic [15:0]         angle_sum;
   logic [9:0]          angle_bin_raw;
   logic [BIN_BITS-1:0] point_bin;
   logic [BIN_BITS-1:0] query_bin;
   logic [BIN_BITS-1:0] query_start;

   assign angle_sum     = {1'b0, req_angle_q6} + 16'd32;
   assign angle_bin_raw = angle_sum[15:6];

   always_comb begin
      if (32'(angle_bin_raw) >= NUM_BINS) begin
         point_bin = BIN_BITS'(32'(angle_bin_raw) - NUM_BINS);
      end else begin
         point_bin = BIN_BITS'(angle_bin_raw);
      end
      if (32'(req_query_angle) >= NUM_BINS) begin
         query_bin = BIN_BITS'(32'(req_query_angle) - NUM_BINS);
      end else begin
         query_bin = BIN_BITS'(req_query_angle);
      end
      if (32'(query_bin) < WINDOW_HALF) begin
         query_start = BIN_BITS'(32'(query_bin) + NUM_BINS - WINDOW_HALF);
      end else begin
         query_start = BIN_BITS'(32'(query_bin) - WINDOW_HALF);
      end
   end

   // check of the word that came back from the table
   logic [DIST_BITS-1:0]  rd_dist;
   logic [STAMP_BITS-1:0] rd_stamp;
   logic [STAMP_BITS-1:0] rd_age;
   logic                  rd_keep;
   logic [DIST_BITS-1:0]  pair_lo;
   logic [DIST_BITS-1:0]  pair_hi;
   logic                  pair_match;
   logic                  point_keep;
   logic                  req_fire;
   logic                  rsp_load;

   assign rd_dist    = rdata_ff[WORD_BITS-1:STAMP_BITS];
   assign rd_stamp   = rdata_ff[STAMP_BITS-1:0];
   assign rd_age     = now_ff - rd_stamp;
   assign rd_keep    = (rd_dist != '0) && (32'(rd_age) < 32'(cfg.max_age));
   assign pair_lo    = (rd_dist < prev_ff) ? rd_dist : prev_ff;
   assign pair_hi    = (rd_dist < prev_ff) ? prev_ff : rd_dist;
   assign pair_match = have_prev_ff && ((pair_hi - pair_lo) < cfg.similarity);
   assign point_keep = (dist_ff > cfg.min_distance) && (dist_ff < cfg.max_distance);

   assign req_ready = (state_ff == ST_IDLE);
   assign req_fire  = req_valid && req_ready;

   always_comb begin
      state_in     = state_ff;
      clr_in       = clr_ff;
      addr_in      = addr_ff;
      cnt_in       = cnt_ff;
      rd_valid_in  = 1'b0;
      rd_last_in   = 1'b0;
      have_prev_in = have_prev_ff;
      prev_in      = prev_ff;
      res_mm_in    = res_mm_ff;
      res_found_in = res_found_ff;
      now_in       = now_ff;
      dist_in      = dist_ff;
      mem_we       = 1'b0;
      mem_waddr    = addr_ff;
      mem_wdata    = '0;
      mem_re       = 1'b0;
      mem_raddr    = addr_ff;
      rsp_load     = 1'b0;

      unique case (state_ff)
         ST_CLEAR: begin
            mem_we    = 1'b1;
            mem_waddr = clr_ff;
            clr_in    = clr_ff + 1'b1;
            if (32'(clr_ff) == NUM_BINS - 1) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_fire) begin
               now_in = req_now_ms[STAMP_BITS-1:0];
               if (req_kind == KIND_POINT) begin
                  addr_in  = point_bin;
                  dist_in  = req_distance_mm;
                  state_in = ST_POINT;
               end else begin
                  addr_in      = query_start;
                  cnt_in       = '0;
                  have_prev_in = 1'b0;
                  state_in     = ST_QUERY;
               end
            end
         end
         ST_POINT: begin
            mem_we    = 1'b1;
            mem_waddr = addr_ff;
            mem_wdata = point_keep ? {dist_ff, now_ff} : '0;
            state_in  = ST_IDLE;
         end
         ST_QUERY: begin
            if (32'(cnt_ff) != WINDOW_LEN) begin
               mem_re      = 1'b1;
               mem_raddr   = addr_ff;
               rd_valid_in = 1'b1;
               rd_last_in  = (32'(cnt_ff) == WINDOW_LEN - 1);
               cnt_in      = cnt_ff + 1'b1;
               if (32'(addr_ff) == NUM_BINS - 1) begin
                  addr_in = '0;
               end else begin
                  addr_in = addr_ff + 1'b1;
               end
            end
            if (rd_valid_ff) begin
               priority if (rd_keep && pair_match) begin
                  res_mm_in    = pair_lo;
                  res_found_in = 1'b1;
                  state_in     = ST_RESP;
               end else if (rd_last_ff) begin
                  res_mm_in    = '0;
                  res_found_in = 1'b0;
                  state_in     = ST_RESP;
               end else if (rd_keep) begin
                  prev_in      = rd_dist;
                  have_prev_in = 1'b1;
               end
            end
         end
         ST_RESP: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_load = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      // output register
      rsp_mm_in    = rsp_mm_ff;
      rsp_found_in = rsp_found_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      if (rsp_load) begin
         rsp_valid_in = 1'b1;
         rsp_mm_in    = res_mm_ff;
         rsp_found_in = res_found_ff;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_result_mm = rsp_mm_ff;
   assign rsp_found     = rsp_found_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_ff       <= '0;
         cnt_ff       <= '0;
         rd_valid_ff  <= 1'b0;
         rd_last_ff   <= 1'b0;
         have_prev_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         cnt_ff       <= cnt_in;
         rd_valid_ff  <= rd_valid_in;
         rd_last_ff   <= rd_last_in;
         have_prev_ff <= have_prev_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      addr_ff      <= addr_in;
      prev_ff      <= prev_in;
      res_mm_ff    <= res_mm_in;
      res_found_ff <= res_found_in;
      now_ff       <= now_in;
      dist_ff      <= dist_in;
      rsp_mm_ff    <= rsp_mm_in;
      rsp_found_ff <= rsp_found_in;
   end

endmodule

// ===== bench/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// range scan store and query testbench
// drives point and query requests with bursty gaps against a stalling
// response side, predicts every query answer from a private copy of the bin
// table and the limits, and checks responses in order after several register
// settings, the extremes among them
// ----------------------------------------------------------------------------
module testbench;
   import rssq_pkg::*;

   localparam int CYCLE_LIMIT = 400000;
   localparam int SETTLE_CYCLES = 24;

   typedef struct {
      bit        kind;
      bit [14:0] angle_q6;
      bit [15:0] dist_mm;
      bit [8:0]  query_angle;
      bit [15:0] now_ms;
   } scan_req_type;

   typedef struct {
      bit [15:0] mm;
      bit        found;
   } range_ans_type;

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 req_valid = 1'b0;
   logic                 req_ready;
   logic                 req_kind = KIND_POINT;
   logic [14:0]          req_angle_q6 = '0;
   logic [15:0]          req_distance_mm = '0;
   logic [8:0]           req_query_angle = '0;
   logic [15:0]          req_now_ms = '0;
   logic                 rsp_valid;
   logic                 rsp_ready = 1'b0;
   logic [15:0]          rsp_result_mm;
   logic                 rsp_found;
   logic                 psel = 1'b0;
   logic                 penable = 1'b0;
   logic                 pwrite = 1'b0;
   logic [ADDR_BITS-1:0] paddr = '0;
   logic [DATA_BITS-1:0] pwdata = '0;
   logic [DATA_BITS-1:0] prdata;
   logic                 pready;

   range_scan_store_and_query_top DUT (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_kind(req_kind),
      .req_angle_q6(req_angle_q6), .req_distance_mm(req_distance_mm),
      .req_query_angle(req_query_angle), .req_now_ms(req_now_ms),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready),
      .rsp_result_mm(rsp_result_mm), .rsp_found(rsp_found),
      .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
      .pwdata(pwdata), .prdata(prdata), .pready(pready)
   );

   always #1 clock = ~clock;

   // predicted table and limits
   bit [15:0] scan_dist [NUM_BINS];
   bit [15:0] scan_stamp [NUM_BINS];
   bit [15:0] lim_min = RST_MIN_DISTANCE;
   bit [15:0] lim_max = RST_MAX_DISTANCE;
   bit [15:0] lim_age = RST_MAX_AGE;
   bit [15:0] lim_sim = RST_SIMILARITY;

   scan_req_type  pending_reqs[$];
   range_ans_type expected_answers[$];

   int error_count = 0;
   int results_seen = 0;
   int cycle_count = 0;
   int gap_max = 0;
   int stall_pct = 0;
   bit [15:0] sim_ms;

   bit req_taken = 1'b0;
   int gap_left = 0;
   int burst_left = 0;
   scan_req_type next_req;

   int hold_left = 0;
   int stall_left = 0;
   bit long_hold_done = 1'b0;

   scan_req_type  seen_req;
   range_ans_type want;

   task automatic store_reading(scan_req_type r);
      int unsigned b;
      b = ((int'(r.angle_q6) + 32) >> 6) % NUM_BINS;
      if (r.dist_mm > lim_min && r.dist_mm < lim_max) begin
         scan_dist[b] = r.dist_mm;
         scan_stamp[b] = r.now_ms;
      end else begin
         scan_dist[b] = '0;
         scan_stamp[b] = '0;
      end
   endtask

   function automatic range_ans_type answer_query(scan_req_type r);
      int unsigned   q;
      int unsigned   idx;
      bit [15:0]     d;
      bit [15:0]     prev;
      bit [15:0]     age;
      bit [15:0]     lo;
      bit [15:0]     hi;
      bit            have_prev;
      range_ans_type ans;
      q = r.query_angle % NUM_BINS;
      ans.mm = '0;
      ans.found = 1'b0;
      have_prev = 1'b0;
      prev = '0;
      for (int i = 0; i < 2 * WINDOW_HALF; i++) begin
         idx = (q + NUM_BINS - WINDOW_HALF + i) % NUM_BINS;
         d = scan_dist[idx];
         age = r.now_ms - scan_stamp[idx];
         if (!ans.found && d != 0 && age < lim_age) begin
            if (have_prev) begin
               lo = (d < prev) ? d : prev;
               hi = (d < prev) ? prev : d;
               if (hi - lo < lim_sim) begin
                  ans.mm = lo;
                  ans.found = 1'b1;
               end
            end
            prev = d;
            have_prev = 1'b1;
         end
      end
      return ans;
   endfunction

   // request driver
   always @(negedge clock) begin
      if (req_valid && !req_taken) begin
         // still waiting for acceptance
      end else if (gap_left > 0) begin
         gap_left--;
         req_valid <= 1'b0;
      end else if (pending_reqs.size() > 0) begin
         next_req = pending_reqs.pop_front();
         req_valid <= 1'b1;
         req_kind <= next_req.kind;
         req_angle_q6 <= next_req.angle_q6;
         req_distance_mm <= next_req.dist_mm;
         req_query_angle <= next_req.query_angle;
         req_now_ms <= next_req.now_ms;
         if (burst_left > 0) begin
            burst_left--;
         end else begin
            burst_left = $urandom_range(1, 32);
            gap_left = (gap_max == 0) ? 0 : $urandom_range(0, gap_max);
         end
      end else begin
         req_valid <= 1'b0;
      end
   end

   // response side stalls, plus one long hold-off while requests keep coming
   always @(negedge clock) begin
      if (hold_left > 0) begin
         hold_left--;
         rsp_ready <= 1'b0;
      end else if (!long_hold_done && results_seen >= 60 && pending_reqs.size() > 100) begin
         long_hold_done = 1'b1;
         hold_left = 600;
         rsp_ready <= 1'b0;
      end else if (stall_left > 0) begin
         stall_left--;
         rsp_ready <= 1'b0;
      end else if ($urandom_range(0, 99) < stall_pct) begin
         stall_left = $urandom_range(0, 5);
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   // monitor: responses are checked before a request accepted on the same edge
   always @(posedge clock) begin
      req_taken <= req_valid && req_ready;
      if (!reset) begin
         if (rsp_valid && rsp_ready) begin
            results_seen++;
            if (expected_answers.size() == 0) begin
               $display("%0t: response with no query outstanding, result_mm %0d found %0b",
                        $time, rsp_result_mm, rsp_found);
               error_count++;
            end else begin
               want = expected_answers.pop_front();
               if (rsp_result_mm !== want.mm) begin
                  $display("%0t: result_mm expected %0d actual %0d",
                           $time, want.mm, rsp_result_mm);
                  error_count++;
               end
               if (rsp_found !== want.found) begin
                  $display("%0t: found expected %0b actual %0b", $time, want.found, rsp_found);
                  error_count++;
               end
            end
         end
         if (req_valid && req_ready) begin
            seen_req.kind = req_kind;
            seen_req.angle_q6 = req_angle_q6;
            seen_req.dist_mm = req_distance_mm;
            seen_req.query_angle = req_query_angle;
            seen_req.now_ms = req_now_ms;
            if (req_kind == KIND_QUERY)
               expected_answers.push_back(answer_query(seen_req));
            else
               store_reading(seen_req);
         end
      end
   end

   task automatic push_point(int angle, int dist_mm, int now_ms);
      scan_req_type r;
      r.kind = KIND_POINT;
      r.angle_q6 = 15'(angle);
      r.dist_mm = 16'(dist_mm);
      r.query_angle = 9'($urandom);
      r.now_ms = 16'(now_ms);
      pending_reqs.push_back(r);
   endtask

   task automatic push_query(int direction, int now_ms);
      scan_req_type r;
      r.kind = KIND_QUERY;
      r.angle_q6 = 15'($urandom);
      r.dist_mm = 16'($urandom);
      r.query_angle = 9'(direction);
      r.now_ms = 16'(now_ms);
      pending_reqs.push_back(r);
   endtask

   // setup and access for a write, then a read back of the same register
   task automatic csr_write(logic [1:0] idx, bit [15:0] val);
      logic [DATA_BITS-1:0] rd;
      @(negedge clock);
      psel <= 1'b1;
      penable <= 1'b0;
      pwrite <= 1'b1;
      paddr <= {idx, 2'b00};
      pwdata <= DATA_BITS'(val);
      @(negedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      @(negedge clock);
      penable <= 1'b0;
      pwrite <= 1'b0;
      @(negedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      rd = prdata;
      @(negedge clock);
      psel <= 1'b0;
      penable <= 1'b0;
      if (rd[15:0] !== val) begin
         $display("%0t: register %0d read back expected %0d actual %0d",
                  $time, idx, val, rd[15:0]);
         error_count++;
      end
      case (idx)
         REG_MIN_DISTANCE: lim_min = val;
         REG_MAX_DISTANCE: lim_max = val;
         REG_MAX_AGE:      lim_age = val;
         REG_SIMILARITY:   lim_sim = val;
         default: ;
      endcase
   endtask

   task automatic wait_drained();
      while (pending_reqs.size() > 0 || req_valid || expected_answers.size() > 0)
         @(posedge clock);
      // a trailing point request may still be writing its bin
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // mostly scans around a hot direction with close readings, some noise
   task automatic add_scan_traffic(int n);
      int hot;
      int base;
      int spread;
      int pick;
      int deg;
      int q;
      scan_req_type r;
      hot = $urandom_range(0, NUM_BINS - 1);
      base = $urandom_range(150, 2800);
      spread = $urandom_range(0, 80);
      repeat (n) begin
         pick = $urandom_range(0, 99);
         if (pick < 4) begin
            hot = $urandom_range(0, NUM_BINS - 1);
            base = $urandom_range(150, 2800);
            spread = $urandom_range(0, 80);
         end
         if ($urandom_range(0, 49) == 0)
            sim_ms = sim_ms + 16'($urandom_range(0, 3000));
         else
            sim_ms = sim_ms + 16'($urandom_range(0, 30));
         if (pick < 12) begin
            r.kind = 1'($urandom);
            r.angle_q6 = 15'($urandom);
            r.dist_mm = 16'($urandom);
            r.query_angle = 9'($urandom);
            r.now_ms = 16'($urandom);
            pending_reqs.push_back(r);
         end else if (pick < 64) begin
            deg = (hot + $urandom_range(0, 12) + NUM_BINS - 6) % NUM_BINS;
            push_point((deg * 64 + 23040 + $urandom_range(0, 63) - 32) % 23040,
                       base + $urandom_range(0, spread), sim_ms);
         end else begin
            q = (hot + $urandom_range(0, 10) + NUM_BINS - 5) % NUM_BINS;
            if (q < 152 && $urandom_range(0, 9) == 0)
               q = q + NUM_BINS;
            push_query(q, sim_ms);
         end
      end
   endtask

   task automatic run_phase(bit [15:0] mn, bit [15:0] mx, bit [15:0] ag, bit [15:0] sm,
                            int n, int gaps, int stalls);
      wait_drained();
      csr_write(REG_MIN_DISTANCE, mn);
      csr_write(REG_MAX_DISTANCE, mx);
      csr_write(REG_MAX_AGE, ag);
      csr_write(REG_SIMILARITY, sm);
      @(posedge clock);
      gap_max = gaps;
      stall_pct = stalls;
      add_scan_traffic(n);
   endtask

   initial begin
      cycle_count = 0;
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("[FAIL] regression broken");
      $finish;
   end

   initial begin
      sim_ms = 16'($urandom);
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed requests at the reset limits
      push_point(23007, 480, 1000);       // bin 359
      push_point(23008, 510, 1000);       // rounds to 360, lands in bin 0
      push_point(95, 900, 1000);
      push_query(0, 1000);
      push_query(357, 1010);              // window wraps upward past 359
      push_query(511, 1000);              // out of range, folds to bin 151
      push_point(32767, 2999, 1000);      // largest angle field, just below max
      push_point(32704, 2950, 1000);      // pair differs by one less than similarity
      push_query(511, 1000);
      push_point(32704, 2949, 1000);      // pair differs by exactly similarity
      push_query(511, 1000);
      push_point(95, 100, 1000);          // at min distance, bin cleared
      push_point(0, 3000, 1000);          // at max distance, bin cleared
      push_query(0, 1000);
      push_point(64, 101, 65500);
      push_point(128, 140, 65500);
      push_query(1, 200);                 // stamp age wraps around 16 bits
      push_query(1, 763);                 // age one below max age
      push_query(1, 764);                 // age equal to max age, stale
      push_point(0, 0, 5);
      push_point(23039, 65535, 0);
      push_query(0, 0);

      run_phase(RST_MIN_DISTANCE, RST_MAX_DISTANCE, RST_MAX_AGE, RST_SIMILARITY, 500, 6, 30);
      run_phase(16'd0, 16'hFFFF, 16'hFFFF, 16'hFFFF, 200, 0, 0);
      run_phase(16'hFFFF, 16'd0, 16'd0, 16'd0, 60, 3, 50);
      repeat (4) begin
         run_phase(16'($urandom_range(0, 400)), 16'($urandom_range(1500, 65535)),
                   16'($urandom_range(20, 3000)), 16'($urandom_range(0, 300)),
                   180, $urandom_range(0, 10), $urandom_range(0, 70));
      end
      run_phase(RST_MIN_DISTANCE, RST_MAX_DISTANCE, RST_MAX_AGE, RST_SIMILARITY, 100, 4, 20);
      wait_drained();

      if (error_count == 0)
         $display("[ OK ] regression clean");
      else
         $display("[FAIL] regression broken");
      $finish;
   end

endmodule

// ===== files.f =====
rtl/rssq_pkg.sv
rtl/rssq_csr.sv
rtl/range_scan_store_and_query_top.sv
bench/testbench.sv
